// ----- rtl/tab_column_symbol_encoder_unit_assert.svh -----
// assertion helpers, sampled on clk_i and quiet while rst_ni is low
`ifndef TAB_COLUMN_SYMBOL_ENCODER_UNIT_ASSERT_SVH
`define TAB_COLUMN_SYMBOL_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tcse_pkg.sv -----
package tcse_pkg;

  localparam int unsigned ROWS        = 7;
  localparam int unsigned DEPTH       = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned WORD_W      = 32;

  typedef logic [ROWS-1:0][7:0] rows_t;

  typedef struct packed {
    rows_t      rows;
    logic       filler;
    logic       bar;
    logic       dots;
    logic       rest;
    logic [2:0] dig;
    logic       eot;
  } col_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_HDR,
    ST_DEC,
    ST_END
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_END    = 2'd1
  } cfg_idx_e;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // column patterns, all symmetric so row order does not matter
  localparam rows_t PAT_FILLER = {CH_SPACE, CH_DASH, CH_SPACE, CH_DASH, CH_SPACE, CH_DASH,
                                  CH_SPACE};
  localparam rows_t PAT_BAR    = {CH_SPACE, CH_PIPE, CH_PIPE, CH_PIPE, CH_PIPE, CH_PIPE,
                                  CH_SPACE};
  localparam rows_t PAT_DOTS   = {CH_SPACE, CH_DASH, CH_DOT, CH_DASH, CH_DOT, CH_DASH,
                                  CH_SPACE};

  // symbol words
  localparam logic [WORD_W-1:0] SYM_BAR      = 32'h0100_0000;
  localparam logic [WORD_W-1:0] SYM_DBL_BAR  = 32'h0200_0000;
  localparam logic [WORD_W-1:0] SYM_REP_L    = 32'h0300_0000;
  localparam logic [WORD_W-1:0] SYM_REP_R    = 32'h0400_0000;
  localparam logic [WORD_W-1:0] DUR_DASH     = 32'h4000_0000;
  localparam logic [WORD_W-1:0] DUR_EQ       = 32'h6000_0000;
  localparam logic [WORD_W-1:0] DUR_PLAIN    = 32'h2000_0000;
  localparam logic [WORD_W-1:0] FX_CARET     = 32'h0800_0000;
  localparam logic [WORD_W-1:0] FX_HAMMER    = 32'h0100_0000;
  localparam logic [WORD_W-1:0] FX_U         = 32'h0200_0000;
  localparam logic [WORD_W-1:0] FX_SLIDE     = 32'h0300_0000;
  localparam logic [WORD_W-1:0] FX_SLASH     = 32'h0400_0000;
  localparam logic [WORD_W-1:0] FINGER_UNIT  = 32'h0010_0000;
  localparam logic [WORD_W-1:0] FX_M         = 32'h0080_0000;
  localparam logic [WORD_W-1:0] FLAG_TRIPLET = 32'h1000_0000;

  localparam int unsigned STRING_ROW [3] = '{1, 3, 5};
  localparam int unsigned STRING_SH_W = 6;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  // one or two digit fret, saturated to 5 bits
  function automatic logic [4:0] fret_of(input logic [7:0] a, input logic [7:0] b,
                                         input logic pair);
    logic [6:0] v;
    v = pair ? ((7'(a[3:0]) << 3) + (7'(a[3:0]) << 1) + 7'(b[3:0])) : 7'(a[3:0]);
    return (v > 7'd31) ? 5'd31 : v[4:0];
  endfunction

endpackage

// ----- rtl/tcse_col_if.sv -----
interface tcse_col_if;
  logic       valid;
  logic       ready;
  logic [7:0] row0_char;
  logic [7:0] row1_char;
  logic [7:0] row2_char;
  logic [7:0] row3_char;
  logic [7:0] row4_char;
  logic [7:0] row5_char;
  logic [7:0] row6_char;
  logic       end_of_tab;

  modport source (
    output valid, row0_char, row1_char, row2_char, row3_char, row4_char, row5_char,
           row6_char, end_of_tab,
    input  ready
  );
  modport sink (
    input  valid, row0_char, row1_char, row2_char, row3_char, row4_char, row5_char,
           row6_char, end_of_tab,
    output ready
  );
endinterface

// ----- rtl/tcse_sym_if.sv -----
interface tcse_sym_if;
  logic        valid;
  logic        ready;
  logic [31:0] symbol_word;
  logic        last_of_run;

  modport source (output valid, symbol_word, last_of_run, input ready);
  modport sink (input valid, symbol_word, last_of_run, output ready);
endinterface

// ----- rtl/tcse_front.sv -----
module tcse_front (
  tcse_col_if.sink         col_i,
  output logic             ent_valid_o,
  output tcse_pkg::col_t   ent_data_o,
  input  logic             ent_ready_i
);

  tcse_pkg::rows_t rows;

  always_comb begin
    rows[0] = col_i.row0_char;
    rows[1] = col_i.row1_char;
    rows[2] = col_i.row2_char;
    rows[3] = col_i.row3_char;
    rows[4] = col_i.row4_char;
    rows[5] = col_i.row5_char;
    rows[6] = col_i.row6_char;
  end

  // classify the column on the way into the queue
  always_comb begin
    ent_data_o.rows   = rows;
    ent_data_o.filler = (rows == tcse_pkg::PAT_FILLER);
    ent_data_o.bar    = (rows == tcse_pkg::PAT_BAR);
    ent_data_o.dots   = (rows == tcse_pkg::PAT_DOTS);
    ent_data_o.rest   = (rows[3] == tcse_pkg::CH_X);
    for (int s = 0; s < 3; s++) begin
      ent_data_o.dig[s] = tcse_pkg::is_digit(rows[tcse_pkg::STRING_ROW[s]]);
    end
    ent_data_o.eot    = col_i.end_of_tab;
  end

  assign ent_valid_o = col_i.valid;
  assign col_i.ready = ent_ready_i;

endmodule

// ----- rtl/tcse_queue.sv -----
module tcse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  tcse_pkg::col_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output tcse_pkg::col_t pop_data_o,
  input  logic           pop_ready_i
);

  tcse_pkg::col_t                    mem_q [tcse_pkg::QUEUE_DEPTH];
  logic [tcse_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [tcse_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [tcse_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              push, pop;

  localparam logic [tcse_pkg::QPTR_W-1:0] PTR_LAST = tcse_pkg::QPTR_W'(tcse_pkg::QUEUE_DEPTH - 1);
  localparam logic [tcse_pkg::QCNT_W-1:0] CNT_FULL = tcse_pkg::QCNT_W'(tcse_pkg::QUEUE_DEPTH);

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/tcse_back.sv -----
module tcse_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcse_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcse_pkg::WORD_W-1:0]      cfg_data_i,
  input  logic                             ent_valid_i,
  input  tcse_pkg::col_t                   ent_data_i,
  output logic                             ent_ready_o,
  tcse_sym_if.source                       sym_o
);

  tcse_pkg::state_e              state_q, state_d;
  tcse_pkg::col_t                win_q [tcse_pkg::DEPTH];
  tcse_pkg::col_t                win_d [tcse_pkg::DEPTH];
  logic [1:0]                    cnt_q, cnt_d;
  logic                          flush_q, flush_d;
  logic                          hdr_sent_q, hdr_sent_d;
  logic [tcse_pkg::WORD_W-1:0]   hdr_word_q, end_word_q;
  logic                          out_valid_q, out_valid_d;
  logic [tcse_pkg::WORD_W-1:0]   out_word_q, out_word_d;
  logic                          out_last_q, out_last_d;
  logic                          slot_free;

  logic                          dec_has;
  logic [tcse_pkg::WORD_W-1:0]   dec_word;
  logic [1:0]                    dec_used;
  logic [2:0]                    pair_s;
  logic                          pair;
  tcse_pkg::col_t                lastc;
  logic [tcse_pkg::WORD_W-1:0]   note;

  localparam logic [1:0] CNT_FULL = 2'(tcse_pkg::DEPTH);

  // decode the front of the window
  always_comb begin
    dec_has  = 1'b1;
    dec_word = '0;
    dec_used = 2'd1;
    note     = '0;
    for (int s = 0; s < 3; s++) begin
      pair_s[s] = win_q[0].dig[s] && (cnt_q > 2'd1) && win_q[1].dig[s];
    end
    pair  = |pair_s;
    lastc = pair ? win_q[1] : win_q[0];
    for (int s = 0; s < 3; s++) begin
      if (win_q[0].dig[s]) begin
        note[s*tcse_pkg::STRING_SH_W +: tcse_pkg::STRING_SH_W] =
          {1'b1, tcse_pkg::fret_of(win_q[0].rows[tcse_pkg::STRING_ROW[s]],
                                   win_q[1].rows[tcse_pkg::STRING_ROW[s]], pair_s[s])};
      end
    end
    if (lastc.rows[6] == tcse_pkg::CH_DASH || lastc.rows[4] == tcse_pkg::CH_DASH ||
        lastc.rows[2] == tcse_pkg::CH_DASH) begin
      note = note | tcse_pkg::DUR_DASH;
    end else if (lastc.rows[6] == tcse_pkg::CH_EQ || lastc.rows[4] == tcse_pkg::CH_EQ ||
                 lastc.rows[2] == tcse_pkg::CH_EQ) begin
      note = note | tcse_pkg::DUR_EQ;
    end else begin
      note = note | tcse_pkg::DUR_PLAIN;
    end
    case (lastc.rows[0])
      tcse_pkg::CH_CARET: note = note | tcse_pkg::FX_CARET;
      tcse_pkg::CH_H:     note = note | tcse_pkg::FX_HAMMER;
      tcse_pkg::CH_U:     note = note | tcse_pkg::FX_U;
      tcse_pkg::CH_S:     note = note | tcse_pkg::FX_SLIDE;
      tcse_pkg::CH_SLASH: note = note | tcse_pkg::FX_SLASH;
      tcse_pkg::CH_1:     note = note | tcse_pkg::FINGER_UNIT;
      tcse_pkg::CH_2:     note = note | (tcse_pkg::FINGER_UNIT << 1);
      tcse_pkg::CH_3:     note = note | tcse_pkg::FINGER_UNIT | (tcse_pkg::FINGER_UNIT << 1);
      tcse_pkg::CH_4:     note = note | (tcse_pkg::FINGER_UNIT << 2);
      tcse_pkg::CH_M:     note = note | tcse_pkg::FX_M;
      default: ;
    endcase
    if (lastc.rows[6] == tcse_pkg::CH_3) begin
      note = note | tcse_pkg::FLAG_TRIPLET;
    end

    if (win_q[0].filler) begin
      dec_has = 1'b0;
    end else if (win_q[0].bar) begin
      if (cnt_q > 2'd1 && win_q[1].bar) begin
        if (cnt_q > 2'd2 && win_q[2].dots) begin
          dec_word = tcse_pkg::SYM_REP_L;
          dec_used = 2'd3;
        end else begin
          dec_word = tcse_pkg::SYM_DBL_BAR;
          dec_used = 2'd2;
        end
      end else begin
        dec_word = tcse_pkg::SYM_BAR;
      end
    end else if (win_q[0].dots) begin
      dec_word = tcse_pkg::SYM_REP_R;
      dec_used = cnt_q;
    end else if (win_q[0].rest) begin
      if (win_q[0].rows[4] == tcse_pkg::CH_DASH) begin
        dec_word = tcse_pkg::DUR_DASH;
      end else if (win_q[0].rows[4] == tcse_pkg::CH_EQ) begin
        dec_word = tcse_pkg::DUR_EQ;
      end else begin
        dec_word = tcse_pkg::DUR_PLAIN;
      end
    end else begin
      dec_word = note;
      dec_used = pair ? 2'd2 : 2'd1;
    end
  end

  assign slot_free   = !out_valid_q || sym_o.ready;
  assign ent_ready_o = (state_q == tcse_pkg::ST_LOAD);

  always_comb begin
    state_d     = state_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    flush_d     = flush_q;
    hdr_sent_d  = hdr_sent_q;
    out_valid_d = out_valid_q && !sym_o.ready;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    case (state_q)
      tcse_pkg::ST_LOAD: begin
        if (ent_valid_i) begin
          win_d[cnt_q] = ent_data_i;
          cnt_d        = cnt_q + 2'd1;
          flush_d      = ent_data_i.eot;
          if (!hdr_sent_q) begin
            state_d = tcse_pkg::ST_HDR;
          end else if (ent_data_i.eot || cnt_q == CNT_FULL - 2'd1) begin
            state_d = tcse_pkg::ST_DEC;
          end
        end
      end
      tcse_pkg::ST_HDR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_word_d  = hdr_word_q;
          out_last_d  = !flush_q;
          hdr_sent_d  = 1'b1;
          state_d     = (flush_q || cnt_q == CNT_FULL) ? tcse_pkg::ST_DEC : tcse_pkg::ST_LOAD;
        end
      end
      tcse_pkg::ST_DEC: begin
        if (!dec_has || slot_free) begin
          if (dec_has) begin
            out_valid_d = 1'b1;
            out_word_d  = dec_word;
            out_last_d  = !flush_q;
          end
          case (dec_used)
            2'd1: begin
              win_d[0] = win_q[1];
              win_d[1] = win_q[2];
            end
            2'd2: begin
              win_d[0] = win_q[2];
            end
            default: ;
          endcase
          cnt_d = cnt_q - dec_used;
          if (!flush_q) begin
            state_d = tcse_pkg::ST_LOAD;
          end else if (cnt_q == dec_used) begin
            state_d = tcse_pkg::ST_END;
          end
        end
      end
      tcse_pkg::ST_END: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_word_d  = end_word_q;
          out_last_d  = 1'b1;
          hdr_sent_d  = 1'b0;
          flush_d     = 1'b0;
          state_d     = tcse_pkg::ST_LOAD;
        end
      end
      default: state_d = tcse_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcse_pkg::ST_LOAD;
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      hdr_sent_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hdr_word_q  <= '0;
      end_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      flush_q     <= flush_d;
      hdr_sent_q  <= hdr_sent_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcse_pkg::CFG_HEADER: hdr_word_q <= cfg_data_i;
          tcse_pkg::CFG_END:    end_word_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign sym_o.valid       = out_valid_q;
  assign sym_o.symbol_word = out_word_q;
  assign sym_o.last_of_run = out_last_q;

endmodule

// ----- rtl/tab_column_symbol_encoder_unit.sv -----
// a column goes into the queue, then into the window; header and symbol words leave through
// the output register; a load that fills the window or ends the tab is followed by one decode
// step (the first load by a header step), and these steps wait while the output is stalled
// after the final column, one decode step per flushed symbol or filler, then the end word
// a 2-deep column queue lets the input side run ahead while the decoder waits on output
// reset (rst_ni low, async) empties the queue and window and clears both registers
module tab_column_symbol_encoder_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcse_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcse_pkg::WORD_W-1:0]      cfg_data_i,
  tcse_col_if.sink                         col_i,
  tcse_sym_if.source                       sym_o
);

  logic           fr_valid, fr_ready;
  tcse_pkg::col_t fr_data;
  logic           q_valid, q_ready;
  tcse_pkg::col_t q_data;

  tcse_front u_front (
    .col_i       (col_i),
    .ent_valid_o (fr_valid),
    .ent_data_o  (fr_data),
    .ent_ready_i (fr_ready)
  );

  tcse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_data_i  (fr_data),
    .push_ready_o (fr_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data),
    .pop_ready_i  (q_ready)
  );

  tcse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ent_valid_i (q_valid),
    .ent_data_i  (q_data),
    .ent_ready_o (q_ready),
    .sym_o       (sym_o)
  );

endmodule

// ----- rtl/tcse_checker.sv -----
`include "tab_column_symbol_encoder_unit_assert.svh"

module tcse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        col_ready_i,
  input logic        sym_valid_i,
  input logic        sym_ready_i,
  input logic [31:0] sym_word_i,
  input logic        sym_last_i
);

  // a stalled output word holds
  `TCSE_ASSERT_NXT(a_sym_hold, sym_valid_i && !sym_ready_i, sym_valid_i && $stable(sym_word_i) && $stable(sym_last_i), "output word changed while stalled")

  // nothing pending right after reset
  `TCSE_ASSERT_IMP(a_no_word_after_reset, $rose(rst_ni), !sym_valid_i, "output valid right after reset")

  // queue comes out of reset empty
  `TCSE_ASSERT_IMP(a_ready_after_reset, $rose(rst_ni), col_ready_i, "input not ready after reset")

endmodule

bind tab_column_symbol_encoder_unit tcse_checker u_tcse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .col_ready_i (col_i.ready),
  .sym_valid_i (sym_o.valid),
  .sym_ready_i (sym_o.ready),
  .sym_word_i  (sym_o.symbol_word),
  .sym_last_i  (sym_o.last_of_run)
);
